### rtl/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg
// Shared constants for the ray and circle intersection pipeline: default
// coordinate format and the limb width that the multipliers are cut into.
// ----------------------------------------------------------------------------
package rci_pkg;

	// Default coordinate width and fraction bits of the fixed-point format.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Width of one partial-product limb in the multipliers.
	localparam int LIMB_W = 32;

endpackage

### rtl/ray_circle_intersect.sv
// ----------------------------------------------------------------------------
// ray_circle_intersect
// Ray against circle test in signed fixed point: discriminant, square root
// and division give the smaller root along the ray and a hit flag.
// ----------------------------------------------------------------------------
// Usage:
// A beat is accepted at a rising edge where start is high and busy is low.
// busy stays low, so a new beat can be taken at every clock edge.
// The seven input fields are sampled at that edge; nothing else is needed.
// The result of an accepted beat is on hit, roots_real and t_value during
// the cycle in which done is high, and done is high for exactly that cycle.
// The square root takes 2*COORD_WIDTH+1 stages (one root bit each) and
// the divider 2*COORD_WIDTH+2+FRAC_BITS stages (one quotient bit each);
// the multiplier and adder stages make up the other fifteen.
// Throughput is one beat per cycle. Results leave in acceptance order.
// Reset clears all valid bits, so beats in flight are dropped and done stays
// low until a new beat has passed through. The receiver cannot stall: each
// result is shown for one cycle only and must be taken then.
// ----------------------------------------------------------------------------
module ray_circle_intersect #(
	parameter int COORD_WIDTH = rci_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rci_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
	input  logic signed [COORD_WIDTH-1:0] circle_center_x,
	input  logic signed [COORD_WIDTH-1:0] circle_center_y,
	input  logic        [COORD_WIDTH-2:0] circle_radius,
	output logic                          done,
	output logic                          hit,
	output logic                          roots_real,
	output logic signed [COORD_WIDTH-1:0] t_value
);

	localparam int CW   = COORD_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int VW   = CW + 1;
	localparam int A_W  = 2 * CW;
	localparam int H_W  = 2 * CW + 2;
	localparam int HM_W = 2 * CW + 1;
	localparam int C_W  = 2 * CW + 3;
	localparam int CM_W = 2 * CW + 2;
	localparam int P2_W = 4 * CW + 3;
	localparam int D_W  = 4 * CW + 2;
	localparam int SW   = D_W / 2;
	localparam int SB_W = 1 + H_W + A_W;
	localparam int N_W  = 2 * CW + 3;
	localparam int M_W  = 2 * CW + 2;
	localparam int Q_W  = M_W + FB;
	localparam int LAT  = 4 * CW + FB + 18;

	// Stage valid bits.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;
	logic done_q;

	// Stage 1: offset from the circle center.
	logic signed [VW-1:0] vx_s1, vy_s1;
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic        [CW-2:0] r_s1;

	always_ff @(posedge clk) begin
		vx_s1 <= VW'(ray_origin_x) - VW'(circle_center_x);
		vy_s1 <= VW'(ray_origin_y) - VW'(circle_center_y);
		dx_s1 <= ray_dir_x;
		dy_s1 <= ray_dir_y;
		r_s1  <= circle_radius;
	end

	// Stage 2: magnitudes and product signs for the first multipliers.
	logic [VW-1:0] vxm_s2, vym_s2;
	logic [CW-1:0] dxm_s2, dym_s2;
	logic [CW-2:0] rm_s2;
	logic          sgx_s2, sgy_s2;

	always_ff @(posedge clk) begin
		vxm_s2 <= vx_s1[VW-1] ? $unsigned(-vx_s1) : $unsigned(vx_s1);
		vym_s2 <= vy_s1[VW-1] ? $unsigned(-vy_s1) : $unsigned(vy_s1);
		dxm_s2 <= dx_s1[CW-1] ? $unsigned(-dx_s1) : $unsigned(dx_s1);
		dym_s2 <= dy_s1[CW-1] ? $unsigned(-dy_s1) : $unsigned(dy_s1);
		rm_s2  <= r_s1;
		sgx_s2 <= vx_s1[VW-1] ^ dx_s1[CW-1];
		sgy_s2 <= vy_s1[VW-1] ^ dy_s1[CW-1];
	end

	// Stages 3 to 5: the seven first-level products.
	logic signed [2*CW:0]   ddx, ddy;
	logic signed [H_W-1:0]  vdx, vdy;
	logic signed [C_W-1:0]  vvx, vvy;
	logic signed [2*CW-2:0] rr;

	rci_mul #(.AW(CW), .BW(CW)) u_mul_ddx (
		.clk(clk), .a_mag(dxm_s2), .b_mag(dxm_s2), .neg(1'b0), .prod(ddx));
	rci_mul #(.AW(CW), .BW(CW)) u_mul_ddy (
		.clk(clk), .a_mag(dym_s2), .b_mag(dym_s2), .neg(1'b0), .prod(ddy));
	rci_mul #(.AW(VW), .BW(CW)) u_mul_vdx (
		.clk(clk), .a_mag(vxm_s2), .b_mag(dxm_s2), .neg(sgx_s2), .prod(vdx));
	rci_mul #(.AW(VW), .BW(CW)) u_mul_vdy (
		.clk(clk), .a_mag(vym_s2), .b_mag(dym_s2), .neg(sgy_s2), .prod(vdy));
	rci_mul #(.AW(VW), .BW(VW)) u_mul_vvx (
		.clk(clk), .a_mag(vxm_s2), .b_mag(vxm_s2), .neg(1'b0), .prod(vvx));
	rci_mul #(.AW(VW), .BW(VW)) u_mul_vvy (
		.clk(clk), .a_mag(vym_s2), .b_mag(vym_s2), .neg(1'b0), .prod(vvy));
	rci_mul #(.AW(CW-1), .BW(CW-1)) u_mul_rr (
		.clk(clk), .a_mag(rm_s2), .b_mag(rm_s2), .neg(1'b0), .prod(rr));

	// Stage 6: quadratic coefficients a, h = b/2 and c.
	logic        [A_W-1:0] a_s6;
	logic signed [H_W-1:0] h_s6;
	logic signed [C_W-1:0] c_s6;

	always_ff @(posedge clk) begin
		a_s6 <= ddx[A_W-1:0] + ddy[A_W-1:0];
		h_s6 <= vdx + vdy;
		c_s6 <= vvx + vvy - C_W'(rr);
	end

	// Stage 7: magnitudes for the second-level products.
	logic        [HM_W-1:0] hm_s7;
	logic        [CM_W-1:0] cm_s7;
	logic                   cneg_s7;
	logic        [A_W-1:0]  a_s7;
	logic signed [H_W-1:0]  h_s7;

	always_ff @(posedge clk) begin
		hm_s7   <= HM_W'(h_s6[H_W-1] ? $unsigned(-h_s6) : $unsigned(h_s6));
		cm_s7   <= CM_W'(c_s6[C_W-1] ? $unsigned(-c_s6) : $unsigned(c_s6));
		cneg_s7 <= c_s6[C_W-1];
		a_s7    <= a_s6;
		h_s7    <= h_s6;
	end

	// Stages 8 to 10: h*h and a*c, with h and a carried alongside.
	logic signed [P2_W-1:0] hh, ac;
	logic        [A_W-1:0]  a_s8, a_s9, a_s10;
	logic signed [H_W-1:0]  h_s8, h_s9, h_s10;

	rci_mul #(.AW(HM_W), .BW(HM_W)) u_mul_hh (
		.clk(clk), .a_mag(hm_s7), .b_mag(hm_s7), .neg(1'b0), .prod(hh));
	rci_mul #(.AW(A_W), .BW(CM_W)) u_mul_ac (
		.clk(clk), .a_mag(a_s7), .b_mag(cm_s7), .neg(cneg_s7), .prod(ac));

	always_ff @(posedge clk) begin
		a_s8  <= a_s7;
		a_s9  <= a_s8;
		a_s10 <= a_s9;
		h_s8  <= h_s7;
		h_s9  <= h_s8;
		h_s10 <= h_s9;
	end

	// Stage 11: discriminant over four.
	logic signed [D_W-1:0] disc_s11;
	logic        [A_W-1:0] a_s11;
	logic signed [H_W-1:0] h_s11;

	always_ff @(posedge clk) begin
		disc_s11 <= D_W'(hh - ac);
		a_s11    <= a_s10;
		h_s11    <= h_s10;
	end

	// Square root of the discriminant; a nonzero direction and a
	// non-negative discriminant ride along as the valid-root flag.
	logic                  sq_ok_in;
	logic                  sq_vld;
	logic [SW-1:0]         sq_root;
	logic [SB_W-1:0]       sq_side;
	logic                  sq_ok;
	logic signed [H_W-1:0] sq_h;
	logic [A_W-1:0]        sq_a;

	assign sq_ok_in = (a_s11 != '0) && !disc_s11[D_W-1];

	rci_isqrt #(.RW(D_W), .SBW(SB_W)) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s11),
		.rad($unsigned(disc_s11)),
		.side_in({sq_ok_in, h_s11, a_s11}),
		.out_valid(sq_vld),
		.root(sq_root),
		.side_out(sq_side)
	);

	assign sq_ok = sq_side[SB_W-1];
	assign sq_h  = sq_side[A_W +: H_W];
	assign sq_a  = sq_side[A_W-1:0];

	// Stage 12: numerator -h - isqrt(disc).
	logic signed [N_W-1:0] numr_s12;
	logic        [A_W-1:0] a_s12;
	logic                  ok_s12;

	always_ff @(posedge clk) begin
		numr_s12 <= -N_W'(sq_h) - $signed(N_W'(sq_root));
		a_s12    <= sq_a;
		ok_s12   <= sq_ok;
	end

	// Stage 13: sign, magnitude and fraction alignment of the dividend.
	logic [Q_W-1:0] dvd_s13;
	logic           neg_s13;
	logic [A_W-1:0] a_s13;
	logic           ok_s13;

	always_ff @(posedge clk) begin
		neg_s13 <= numr_s12[N_W-1];
		dvd_s13 <= {M_W'(numr_s12[N_W-1] ? $unsigned(-numr_s12) : $unsigned(numr_s12)),
			{FB{1'b0}}};
		a_s13   <= a_s12;
		ok_s13  <= ok_s12;
	end

	// Restoring divider, one quotient bit per stage.
	logic [A_W-1:0] dv_rem [1:Q_W];
	logic [Q_W-1:0] dv_q   [1:Q_W];
	logic [Q_W-1:0] dv_dvd [1:Q_W];
	logic [A_W-1:0] dv_a   [1:Q_W];
	logic           dv_neg [1:Q_W];
	logic           dv_ok  [1:Q_W];
	logic           dv_vld [1:Q_W];

	logic [A_W-1:0] ds_rem [Q_W];
	logic [Q_W-1:0] ds_q   [Q_W];
	logic [Q_W-1:0] ds_dvd [Q_W];
	logic [A_W-1:0] ds_a   [Q_W];
	logic           ds_neg [Q_W];
	logic           ds_ok  [Q_W];
	logic [A_W:0]   ds_cat [Q_W];
	logic [A_W:0]   ds_dif [Q_W];
	logic           ds_ge  [Q_W];

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				ds_rem[k] = '0;
				ds_q[k]   = '0;
				ds_dvd[k] = dvd_s13;
				ds_a[k]   = a_s13;
				ds_neg[k] = neg_s13;
				ds_ok[k]  = ok_s13;
			end else begin
				ds_rem[k] = dv_rem[k];
				ds_q[k]   = dv_q[k];
				ds_dvd[k] = dv_dvd[k];
				ds_a[k]   = dv_a[k];
				ds_neg[k] = dv_neg[k];
				ds_ok[k]  = dv_ok[k];
			end
			ds_cat[k] = {ds_rem[k], ds_dvd[k][Q_W-1]};
			ds_ge[k]  = ds_cat[k] >= {1'b0, ds_a[k]};
			ds_dif[k] = ds_cat[k] - {1'b0, ds_a[k]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < Q_W; k++) begin
			dv_rem[k+1] <= ds_ge[k] ? ds_dif[k][A_W-1:0] : ds_cat[k][A_W-1:0];
			dv_q[k+1]   <= {ds_q[k][Q_W-2:0], ds_ge[k]};
			dv_dvd[k+1] <= ds_dvd[k] << 1;
			dv_a[k+1]   <= ds_a[k];
			dv_neg[k+1] <= ds_neg[k];
			dv_ok[k+1]  <= ds_ok[k];
		end
	end

	// Stage 14: round a negative quotient toward minus infinity.
	logic [Q_W:0] qr_s14;
	logic         neg_s14;
	logic         ok_s14;

	always_ff @(posedge clk) begin
		qr_s14  <= (Q_W+1)'(dv_q[Q_W]) +
			(Q_W+1)'(dv_neg[Q_W] && (dv_rem[Q_W] != '0));
		neg_s14 <= dv_neg[Q_W];
		ok_s14  <= dv_ok[Q_W];
	end

	// Saturation to the coordinate range.
	logic [Q_W:0]         q_lim;
	logic [Q_W:0]         q_sel;
	logic [Q_W:0]         q_neg;
	logic signed [CW-1:0] t_next;

	always_comb begin
		q_lim = (Q_W+1)'(1) << (CW - 1);
		if (neg_s14) begin
			q_sel  = (qr_s14 > q_lim) ? q_lim : qr_s14;
			q_neg  = -q_sel;
			t_next = $signed(q_neg[CW-1:0]);
		end else begin
			q_sel  = (qr_s14 >= q_lim) ? (q_lim - (Q_W+1)'(1)) : qr_s14;
			q_neg  = '0;
			t_next = $signed(q_sel[CW-1:0]);
		end
	end

	// Output registers.
	logic                 hit_q, roots_q;
	logic signed [CW-1:0] t_q;

	always_ff @(posedge clk) begin
		roots_q <= ok_s14;
		hit_q   <= ok_s14 && !neg_s14;
		t_q     <= ok_s14 ? t_next : '0;
	end

	// Valid bits for every stage outside the square root unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			done_q  <= 1'b0;
			for (int k = 1; k <= Q_W; k++) begin
				dv_vld[k] <= 1'b0;
			end
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= sq_vld;
			vld_s13 <= vld_s12;
			dv_vld[1] <= vld_s13;
			for (int k = 2; k <= Q_W; k++) begin
				dv_vld[k] <= dv_vld[k-1];
			end
			vld_s14 <= dv_vld[Q_W];
			done_q  <= vld_s14;
		end
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign hit        = hit_q;
	assign roots_real = roots_q;
	assign t_value    = t_q;

	// Every accepted beat produces a result, shown with done high.
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat did not produce a result on time");

	// No result appears without an earlier accepted beat.
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching accepted beat");

	// A hit requires real roots.
	a_hit_real: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> roots_real)
		else $error("hit reported without real roots");

	// Without real roots the root value is zero.
	a_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !roots_real) |-> (t_value == '0))
		else $error("nonzero root value without real roots");

endmodule

### rtl/rci_mul.sv
// ----------------------------------------------------------------------------
// rci_mul
// Three-stage signed multiplier on magnitudes: limb partial products, then
// their sum, then the sign is applied. The result is AW+BW+1 bits, signed.
// ----------------------------------------------------------------------------
module rci_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic [AW-1:0]           a_mag,
	input  logic [BW-1:0]           b_mag,
	input  logic                    neg,
	output logic signed [AW+BW:0]   prod
);
	import rci_pkg::*;

	localparam int NA   = (AW + LIMB_W - 1) / LIMB_W;
	localparam int NB   = (BW + LIMB_W - 1) / LIMB_W;
	localparam int SUMW = (NA + NB) * LIMB_W;
	localparam int PW   = AW + BW + 1;

	logic [NA*LIMB_W-1:0] a_pad;
	logic [NB*LIMB_W-1:0] b_pad;
	logic [2*LIMB_W-1:0]  pp_s1 [NA][NB];
	logic                 neg_s1;
	logic [SUMW-1:0]      acc;
	logic [AW+BW-1:0]     mag_s2;
	logic                 neg_s2;

	assign a_pad = (NA*LIMB_W)'(a_mag);
	assign b_pad = (NB*LIMB_W)'(b_mag);

	// Stage 1: one limb by limb product per pair.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W]) *
					(2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
			end
		end
		neg_s1 <= neg;
	end

	// Stage 2: weighted sum of the partial products.
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SUMW'(pp_s1[i][j]) << ((i + j) * LIMB_W));
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= acc[AW+BW-1:0];
		neg_s2 <= neg_s1;
	end

	// Stage 3: apply the sign.
	always_ff @(posedge clk) begin
		if (neg_s2) begin
			prod <= -$signed(PW'(mag_s2));
		end else begin
			prod <= $signed(PW'(mag_s2));
		end
	end

endmodule

### rtl/rci_isqrt.sv
// ----------------------------------------------------------------------------
// rci_isqrt
// Pipelined integer square root, rounded down: one root bit per stage, with
// a sideband word and a valid bit that travel alongside each radicand.
// ----------------------------------------------------------------------------
module rci_isqrt #(
	parameter int RW  = 130,
	parameter int SBW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [RW-1:0]   rad,
	input  logic [SBW-1:0]  side_in,
	output logic            out_valid,
	output logic [RW/2-1:0] root,
	output logic [SBW-1:0]  side_out
);

	localparam int N  = RW / 2;
	localparam int RM = N + 2;

	logic [RM-1:0]  rem_s  [1:N];
	logic [N-1:0]   root_s [1:N];
	logic [RW-1:0]  rad_s  [1:N];
	logic [SBW-1:0] side_s [1:N];
	logic           vld_s  [1:N];

	logic [RM-1:0]  src_rem  [N];
	logic [N-1:0]   src_root [N];
	logic [RW-1:0]  src_rad  [N];
	logic [SBW-1:0] src_side [N];
	logic [RM+1:0]  cat      [N];
	logic [RM+1:0]  trial    [N];
	logic [RM+1:0]  diff     [N];
	logic           ge       [N];

	// Each stage brings down two radicand bits and tries the next root bit.
	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				src_rem[k]  = '0;
				src_root[k] = '0;
				src_rad[k]  = rad;
				src_side[k] = side_in;
			end else begin
				src_rem[k]  = rem_s[k];
				src_root[k] = root_s[k];
				src_rad[k]  = rad_s[k];
				src_side[k] = side_s[k];
			end
			cat[k]   = {src_rem[k], src_rad[k][RW-1 -: 2]};
			trial[k] = {2'b00, src_root[k], 2'b01};
			ge[k]    = cat[k] >= trial[k];
			diff[k]  = cat[k] - trial[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			rem_s[k+1]  <= ge[k] ? diff[k][RM-1:0] : cat[k][RM-1:0];
			root_s[k+1] <= {src_root[k][N-2:0], ge[k]};
			rad_s[k+1]  <= src_rad[k] << 2;
			side_s[k+1] <= src_side[k];
		end
	end

	// Valid bits follow the data down the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= N; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= N; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N];
	assign side_out  = side_s[N];

endmodule
